@@ rtl/core/slc_pkg.sv @@
package slc_pkg;

  // Fixed field widths of the block's ports.
  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 20;
  localparam int LEVEL_W  = 16;
  localparam int THR_W    = 16;
  localparam int BETA_W   = 16;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  // Default structural parameters.
  localparam int WINDOW_LEN_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 12;

  // Configuration reset values.
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(2641);
  localparam logic [THR_W-1:0]  JUMP_RESET = THR_W'(2560);
  localparam logic [THR_W-1:0]  HOLD_RESET = THR_W'(512);
  localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(6554);

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 2'd0,
    REG_JUMP = 2'd1,
    REG_HOLD = 2'd2,
    REG_BETA = 2'd3
  } slc_reg_t;

  // Live configuration handed to the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [THR_W-1:0]  jump;
    logic [THR_W-1:0]  hold;
    logic [BETA_W-1:0] beta;
  } slc_cfg_t;

  // Step strobes from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic level;
    logic update;
    logic product;
    logic scale;
    logic finish;
  } slc_cmd_t;

endpackage

@@ rtl/core/slc_ctrl.sv @@
module slc_ctrl import slc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output slc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_UPDATE,
    ST_PRODUCT,
    ST_SCALE,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // One strobe per step of the sequence.
  always_comb begin
    cmd         = '0;
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.level   = (state == ST_LEVEL);
    cmd.update  = (state == ST_UPDATE);
    cmd.product = (state == ST_PRODUCT);
    cmd.scale   = (state == ST_SCALE);
    cmd.finish  = (state == ST_FINISH) && out_free;
  end

  // Sequencer and result-beat flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A finished item raises the result beat; a taken beat with nothing new drops it.
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LEVEL;
          end
        end
        ST_LEVEL:   state <= ST_UPDATE;
        ST_UPDATE:  state <= ST_PRODUCT;
        ST_PRODUCT: state <= ST_SCALE;
        ST_SCALE:   state <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/slc_datapath.sv @@
module slc_datapath import slc_pkg::*; #(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  slc_cmd_t            cmd,
  input  slc_cfg_t            cfg,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [LEVEL_W-1:0]  level_now,
  output logic [LEVEL_W-1:0]  level_averaged,
  output logic [LEVEL_W-1:0]  level_held,
  output logic [LEVEL_W-1:0]  level_smoothed,
  output logic [SAMPLE_W-1:0] raw_minimum,
  output logic [SAMPLE_W-1:0] raw_maximum
);

  localparam int SB     = SAMPLE_BITS;
  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SB + IDX_W;
  localparam int P1_W   = SB + GAIN_W;
  localparam int LV_W   = P1_W + 1;
  localparam int P2_W   = SUM_W + GAIN_W;
  localparam int QF_W   = P2_W + 1 - 8;
  localparam int QW     = LEVEL_W + IDX_W;
  localparam int K      = QW + IDX_W;
  localparam int RECIP  = ((1 << K) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [P2_W:0]     AVG_HALF = (P2_W+1)'(128 * WINDOW_LEN);
  localparam logic [QF_W-1:0]   AVG_SAT  = QF_W'(65536 * WINDOW_LEN);
  localparam logic [K-1:0]      RECIP_K  = K'(RECIP);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WINDOW_LEN - 1);
  localparam logic [SUM_W-1:0]  LEN_SUM  = SUM_W'(WINDOW_LEN);

  // Window storage and running state.
  logic [SB-1:0]      window [WINDOW_LEN];
  logic [IDX_W-1:0]   window_index;
  logic [SUM_W-1:0]   window_sum;
  logic               primed;
  logic [LEVEL_W-1:0] previous_level;
  logic [LEVEL_W-1:0] held_level;
  logic [LEVEL_W-1:0] smoothed_level;
  logic [SB-1:0]      min_seen;
  logic [SB-1:0]      max_seen;

  // Per-item working registers.
  logic [SB-1:0]         s_reg;
  logic [P1_W-1:0]       p1;
  logic [LEVEL_W-1:0]    level;
  logic [P2_W-1:0]       p2;
  logic signed [33:0]    p3;
  logic                  avg_sat;
  logic [QW+K-1:0]       pq;

  // Combinational helpers.
  logic [SB-1:0]         s_in;
  logic [LV_W-1:0]       lv_full;
  logic [LEVEL_W-1:0]    diff;
  logic                  refill;
  logic [P2_W:0]         q_round;
  logic [QF_W-1:0]       q_full;
  logic signed [16:0]    delta;
  logic signed [16:0]    beta_s;
  logic signed [33:0]    step_full;
  logic signed [33:0]    smoothed_next;

  assign s_in    = sample[SB-1:0];
  assign lv_full = (LV_W'(p1) + LV_W'(128)) >> 8;
  assign diff    = (previous_level > level) ? (previous_level - level)
                                            : (level - previous_level);
  assign refill  = !primed || (diff > cfg.jump);
  assign q_round = (P2_W+1)'(p2) + AVG_HALF;
  assign q_full  = q_round[P2_W:8];
  assign delta   = $signed({1'b0, level}) - $signed({1'b0, smoothed_level});
  assign beta_s  = $signed({1'b0, cfg.beta});
  assign step_full     = p3 + 34'sd32768;
  assign smoothed_next = $signed({18'b0, smoothed_level}) + (step_full >>> 16);

  // Capture the sample, start the gain product and track the extremes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen <= '1;
      max_seen <= '0;
    end else if (cmd.capture) begin
      if (s_in < min_seen) begin
        min_seen <= s_in;
      end
      if (s_in > max_seen) begin
        max_seen <= s_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_reg <= s_in;
      p1    <= P1_W'(s_in) * P1_W'(cfg.gain);
    end
  end

  // Round and saturate the level.
  always_ff @(posedge clk) begin
    if (cmd.level) begin
      level <= (|lv_full[LV_W-1:LEVEL_W]) ? '1 : lv_full[LEVEL_W-1:0];
    end
  end

  // Window, hold and previous-level update.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_index   <= '0;
      window_sum     <= '0;
      primed         <= 1'b0;
      previous_level <= '0;
      held_level     <= '0;
    end else if (cmd.update) begin
      if (refill) begin
        window_sum <= SUM_W'(s_reg) * LEN_SUM;
        primed     <= 1'b1;
      end else begin
        window_sum <= window_sum - SUM_W'(window[window_index]) + SUM_W'(s_reg);
      end
      window_index   <= (window_index == IDX_LAST) ? '0 : window_index + 1'b1;
      if (diff >= cfg.hold) begin
        held_level <= level;
      end
      previous_level <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        if (refill || (window_index == IDX_W'(i))) begin
          window[i] <= s_reg;
        end
      end
    end
  end

  // Average and smoothing products.
  always_ff @(posedge clk) begin
    if (cmd.product) begin
      p2 <= P2_W'(window_sum) * P2_W'(cfg.gain);
      p3 <= 34'(delta) * 34'(beta_s);
    end
  end

  // Divide by the window length through its reciprocal; commit the smoother.
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      avg_sat <= (q_full >= AVG_SAT);
      pq      <= (QW+K)'(q_full[QW-1:0]) * (QW+K)'(RECIP_K);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_level <= '0;
    end else if (cmd.scale) begin
      smoothed_level <= smoothed_next[LEVEL_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      level_now      <= level;
      level_averaged <= avg_sat ? '1 : pq[K +: LEVEL_W];
      level_held     <= held_level;
      level_smoothed <= smoothed_level;
      raw_minimum    <= SAMPLE_W'(min_seen);
      raw_maximum    <= SAMPLE_W'(max_seen);
    end
  end

endmodule

@@ rtl/core/sound_level_conditioner.sv @@
// Sound level conditioner: converts one raw sound-sensor ADC sample per beat
// into Q8.8 decibel levels (instantaneous, window average, hysteresis hold and
// first-order IIR smoothed) plus the raw minimum and maximum since reset. An
// input beat is taken only while the block is idle, so a new sample waits
// until the last one has finished; the next sample can be taken in the same
// cycle that the result beat appears. Each sample runs through the
// controller's fixed step sequence: gain multiply, level rounding, window
// update, average and smoothing multiplies, then the reciprocal multiply that
// divides by the window length. A result that is not taken stalls the block
// in its last step. Configuration writes are registered and must be made
// while no sample is in flight.
module sound_level_conditioner import slc_pkg::*; #(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LEVEL_W-1:0]   level_now,
  output logic [LEVEL_W-1:0]   level_averaged,
  output logic [LEVEL_W-1:0]   level_held,
  output logic [LEVEL_W-1:0]   level_smoothed,
  output logic [SAMPLE_W-1:0]  raw_minimum,
  output logic [SAMPLE_W-1:0]  raw_maximum
);

  slc_cfg_t cfg;
  slc_cmd_t cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain <= GAIN_RESET;
      cfg.jump <= JUMP_RESET;
      cfg.hold <= HOLD_RESET;
      cfg.beta <= BETA_RESET;
    end else if (cfg_write_en) begin
      unique case (slc_reg_t'(cfg_index))
        REG_GAIN: cfg.gain <= cfg_data[GAIN_W-1:0];
        REG_JUMP: cfg.jump <= cfg_data[THR_W-1:0];
        REG_HOLD: cfg.hold <= cfg_data[THR_W-1:0];
        REG_BETA: cfg.beta <= cfg_data[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  slc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  slc_datapath #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .sample         (sample),
    .level_now      (level_now),
    .level_averaged (level_averaged),
    .level_held     (level_held),
    .level_smoothed (level_smoothed),
    .raw_minimum    (raw_minimum),
    .raw_maximum    (raw_maximum)
  );

endmodule
